// ===== rtl/qxm_pkg.sv =====
// Shared types and constants for the quad X motor mixer.
// Holds the action and sequencer codes, field offsets and request structs.
// No dependencies.
`timescale 1ns / 1ps

package qxm_pkg;

	typedef enum logic [2:0] {
		ACT_MIX    = 3'd0,
		ACT_FOUR   = 3'd1,
		ACT_ONE    = 3'd2,
		ACT_TEST   = 3'd3,
		ACT_ARM    = 3'd4,
		ACT_DISARM = 3'd5,
		ACT_CLEAR  = 3'd6,
		ACT_READ   = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_GAIN  = 3'd1,
		ST_CLAMP = 3'd2,
		ST_DUTY  = 3'd3,
		ST_WRITE = 3'd4,
		ST_TMUL  = 3'd5,
		ST_TDIV  = 3'd6,
		ST_DONE  = 3'd7
	} state_t;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_RESOLUTION = 1'b0;
	localparam cfg_idx_t REG_GAIN       = 1'b1;

	localparam int CFG_W     = 16;
	localparam int RES_REG_W = 4;
	localparam int RES_W     = 5;
	localparam logic [RES_REG_W-1:0] RES_RESET  = 4'd8;
	localparam logic [CFG_W-1:0]     GAIN_RESET = 16'd4428;

	// Input word layout
	localparam int VAL_W       = 16;
	localparam int IDX_W       = 3;
	localparam int PCT_W       = 7;
	localparam int ACT_W       = 3;
	localparam int OFS_THRUST  = 0;
	localparam int OFS_ROLL    = 16;
	localparam int OFS_PITCH   = 32;
	localparam int OFS_YAW     = 48;
	localparam int OFS_DUTY0   = 64;
	localparam int OFS_INDEX   = 128;
	localparam int OFS_SINGLE  = 131;
	localparam int OFS_PCT     = 147;
	localparam int IN_USED_W   = 154;
	localparam int IN_TDATA_W  = 160;

	// Arithmetic
	localparam int MUL_W       = 25;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int GAIN_SHIFT  = 16;
	localparam int SUM_W       = 18;
	localparam int RAW_W       = 19;
	localparam int VAL_MAX_W   = 17;
	localparam int PROD_IN_W   = 23;
	localparam int RECIP_SHIFT = 30;
	localparam logic [23:0]      RECIP   = 24'd10737419;  // ceil(2^30 / 100)
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 wr;
		logic                 clr;
		logic [1:0]           motor;
		logic [VAL_MAX_W-1:0] value;
	} stat_req_t;

endpackage

// ===== rtl/qxm_mul.sv =====
// Shared signed multiplier of the mixer, registered at its output.
// Depends on qxm_pkg for the request struct and operand width.
`timescale 1ns / 1ps

module qxm_mul (
	input  logic                                clk,
	input  qxm_pkg::mul_req_t                   req,
	output logic signed [qxm_pkg::PROD_W-1:0]   prod
);

	logic signed [qxm_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/qxm_stats.sv =====
// Per-motor usage statistics: minimum, maximum, saturating sum and count.
// Depends on qxm_pkg for the update request struct.
`timescale 1ns / 1ps

module qxm_stats #(
	parameter int FRAC_BITS   = 12,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qxm_pkg::stat_req_t              req,
	output logic [FRAC_BITS:0]              rd_min,
	output logic [FRAC_BITS:0]              rd_max,
	output logic [COUNT_WIDTH+FRAC_BITS-1:0] rd_total,
	output logic [COUNT_WIDTH-1:0]          rd_samples
);

	localparam int V_W = FRAC_BITS + 1;
	localparam int T_W = COUNT_WIDTH + FRAC_BITS;
	localparam logic [T_W-1:0] SUM_MAX = {{COUNT_WIDTH{1'b1}}, {FRAC_BITS{1'b0}}};

	logic [V_W-1:0]         min_q [4];
	logic [V_W-1:0]         max_q [4];
	logic [T_W-1:0]         sum_q [4];
	logic [COUNT_WIDTH-1:0] cnt_q [4];

	logic [V_W-1:0]         v;
	logic [T_W:0]           sum_ext;
	logic [T_W-1:0]         sum_nx;
	logic [COUNT_WIDTH-1:0] cnt_nx;
	logic [V_W-1:0]         min_nx;
	logic [V_W-1:0]         max_nx;
	logic                   first;

	always_comb begin
		v       = req.value[V_W-1:0];
		first   = (cnt_q[req.motor] == '0);
		sum_ext = {1'b0, sum_q[req.motor]} + (T_W+1)'(v);
		sum_nx  = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[T_W-1:0];
		cnt_nx  = (&cnt_q[req.motor]) ? cnt_q[req.motor] : cnt_q[req.motor] + 1'b1;
		min_nx  = (first || v < min_q[req.motor]) ? v : min_q[req.motor];
		max_nx  = (first || v > max_q[req.motor]) ? v : max_q[req.motor];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (req.clr) begin
			for (int i = 0; i < 4; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (req.wr) begin
			min_q[req.motor] <= min_nx;
			max_q[req.motor] <= max_nx;
			sum_q[req.motor] <= sum_nx;
			cnt_q[req.motor] <= cnt_nx;
		end
	end

	assign rd_min     = min_q[req.motor];
	assign rd_max     = max_q[req.motor];
	assign rd_total   = sum_q[req.motor];
	assign rd_samples = cnt_q[req.motor];

endmodule

// ===== rtl/quad_x_motor_mixer_pwm_core.sv =====
// Top level of the quad X motor mixer: stream channels, sequencer, duty words.
// Depends on qxm_pkg, qxm_mul (shared multiplier) and qxm_stats (statistics).
`timescale 1ns / 1ps

// Usage
//  Input channel s_*: one command word per handshake; s_tuser carries the
//  action code, s_tdata the operands. Output channel m_*: one result word per
//  command; m_tuser is the status flag (0 done, 1 ignored).
//  Configuration: cfg_wen writes cfg_wdata into register cfg_index (0 duty
//  resolution, 1 mixer gain) at the clock edge; write only while idle.
//  Sequencing: the sequencer walks the single shared multiplier once or twice
//  per motor. Mix takes four steps a motor: gain product, clamp, duty product,
//  write; four duties and one motor skip the gain product; test runs a level
//  product, a divide product and a write; arm, disarm, clear, read and ignored
//  commands go straight to the finish step, where the result is registered.
//  s_tready is high only while the sequencer is idle; a new command is taken
//  while the previous result still waits in the output register.
//  Receiver stall: a finished result is held in its sequencer step until the
//  output register is free, so nothing is lost; the input stays closed then.
//  Reset: disarmed, all duty words and statistics zero, resolution 8, gain
//  4428, output register empty.

module quad_x_motor_mixer_pwm_core #(
	parameter int FRAC_BITS      = 12,
	parameter int MAX_RESOLUTION = 14,
	parameter int COUNT_WIDTH    = 32,
	localparam int OUT_BITS = 4 * MAX_RESOLUTION + 5 + 2 * (FRAC_BITS + 1)
	                        + 2 * COUNT_WIDTH + FRAC_BITS,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wen,
	input  qxm_pkg::cfg_idx_t                  cfg_index,
	input  logic [qxm_pkg::CFG_W-1:0]          cfg_wdata,
	// command stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata, low bit up: thrust, roll, pitch, yaw, duty_front_right,
	// duty_rear_right, duty_rear_left, duty_front_left, motor_index,
	// single_value, motor_test_level, zero fill
	input  logic [qxm_pkg::IN_TDATA_W-1:0]     s_tdata,
	// s_tuser: action
	input  logic [qxm_pkg::ACT_W-1:0]          s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata, low bit up: pwm_front_right, pwm_rear_right, pwm_rear_left,
	// pwm_front_left, updated_mask, armed_flag, stat_minimum, stat_maximum,
	// stat_total, stat_samples, zero fill
	output logic [OUT_W-1:0]                   m_tdata,
	// m_tuser: status
	output logic                               m_tuser
);

	localparam int V_W  = FRAC_BITS + 1;
	localparam int T_W  = COUNT_WIDTH + FRAC_BITS;
	localparam int MR   = MAX_RESOLUTION;
	localparam int FS_W = MAX_RESOLUTION + 1;
	localparam logic signed [qxm_pkg::RAW_W-1:0] ONE_Q =
		qxm_pkg::RAW_W'(1) << FRAC_BITS;

	qxm_pkg::state_t  state_q, state_nx;
	qxm_pkg::action_t action_q, act_in;

	logic [qxm_pkg::RES_REG_W-1:0]  res_q;
	logic [qxm_pkg::CFG_W-1:0]      gain_q;
	logic                           armed_q;
	logic [MR-1:0]                  duty_q [4];
	logic [qxm_pkg::IN_USED_W-1:0]  item_q;
	logic [1:0]                     motor_q;
	logic                           status_q;
	logic [3:0]                     mask_q;
	logic [V_W-1:0]                 v_q;
	logic                           m_tvalid_q;
	logic [OUT_W-1:0]               m_tdata_q;
	logic                           m_tuser_q;

	qxm_pkg::mul_req_t  mul_req;
	qxm_pkg::stat_req_t stat_req;
	logic signed [qxm_pkg::PROD_W-1:0] prod;

	logic [FRAC_BITS:0]       st_min, st_max;
	logic [T_W-1:0]           st_total;
	logic [COUNT_WIDTH-1:0]   st_samples;

	logic                           accept, out_free, ignore_in, more;
	logic [qxm_pkg::IDX_W-1:0]      idx_in;
	logic [qxm_pkg::RES_W-1:0]      res_eff;
	logic [FS_W-1:0]                fs_full;
	logic [MR-1:0]                  fs;
	logic signed [qxm_pkg::VAL_W-1:0] thrust, roll, pitch, yaw, direct;
	logic signed [qxm_pkg::SUM_W-1:0] sum_sel, gterm;
	logic signed [qxm_pkg::RAW_W-1:0] raw;
	logic [V_W-1:0]                 v_clamp;
	logic [qxm_pkg::PCT_W-1:0]      pct, pct_c;
	logic [MR-1:0]                  duty_new;
	logic                           show_stats;
	logic [OUT_W-1:0]               out_word;

	qxm_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	qxm_stats #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (stat_req),
		.rd_min     (st_min),
		.rd_max     (st_max),
		.rd_total   (st_total),
		.rd_samples (st_samples)
	);

	// Decode of the incoming word and of the latched operands
	always_comb begin
		act_in    = qxm_pkg::action_t'(s_tuser);
		idx_in    = s_tdata[qxm_pkg::OFS_INDEX +: qxm_pkg::IDX_W];
		ignore_in = 1'b0;
		case (act_in)
			qxm_pkg::ACT_MIX, qxm_pkg::ACT_FOUR: ignore_in = !armed_q;
			qxm_pkg::ACT_ONE:                    ignore_in = !armed_q || idx_in[2];
			qxm_pkg::ACT_TEST, qxm_pkg::ACT_READ: ignore_in = idx_in[2];
			default:                             ignore_in = 1'b0;
		endcase

		thrust = item_q[qxm_pkg::OFS_THRUST +: qxm_pkg::VAL_W];
		roll   = item_q[qxm_pkg::OFS_ROLL   +: qxm_pkg::VAL_W];
		pitch  = item_q[qxm_pkg::OFS_PITCH  +: qxm_pkg::VAL_W];
		yaw    = item_q[qxm_pkg::OFS_YAW    +: qxm_pkg::VAL_W];
		pct    = item_q[qxm_pkg::OFS_PCT    +: qxm_pkg::PCT_W];
		pct_c  = (pct > qxm_pkg::PCT_MAX) ? qxm_pkg::PCT_MAX : pct;

		// X layout: front right, rear right, rear left, front left
		case (motor_q)
			2'd0:    sum_sel = -qxm_pkg::SUM_W'(roll) + qxm_pkg::SUM_W'(pitch)
			                   + qxm_pkg::SUM_W'(yaw);
			2'd1:    sum_sel = -qxm_pkg::SUM_W'(roll) - qxm_pkg::SUM_W'(pitch)
			                   - qxm_pkg::SUM_W'(yaw);
			2'd2:    sum_sel = qxm_pkg::SUM_W'(roll) - qxm_pkg::SUM_W'(pitch)
			                   + qxm_pkg::SUM_W'(yaw);
			default: sum_sel = qxm_pkg::SUM_W'(roll) + qxm_pkg::SUM_W'(pitch)
			                   - qxm_pkg::SUM_W'(yaw);
		endcase

		if (action_q == qxm_pkg::ACT_ONE) begin
			direct = item_q[qxm_pkg::OFS_SINGLE +: qxm_pkg::VAL_W];
		end else begin
			direct = item_q[qxm_pkg::OFS_DUTY0 + qxm_pkg::VAL_W * motor_q +: qxm_pkg::VAL_W];
		end

		// floor shift of the gain product
		gterm = prod[qxm_pkg::GAIN_SHIFT +: qxm_pkg::SUM_W];
		if (action_q == qxm_pkg::ACT_MIX) begin
			raw = qxm_pkg::RAW_W'(thrust) + qxm_pkg::RAW_W'(gterm);
		end else begin
			raw = qxm_pkg::RAW_W'(direct);
		end
		if (raw < 0) begin
			v_clamp = '0;
		end else if (raw > ONE_Q) begin
			v_clamp = ONE_Q[V_W-1:0];
		end else begin
			v_clamp = raw[V_W-1:0];
		end

		// full scale duty from the resolution register
		if (res_q == '0) begin
			res_eff = qxm_pkg::RES_W'(1);
		end else if ({1'b0, res_q} > qxm_pkg::RES_W'(MAX_RESOLUTION)) begin
			res_eff = qxm_pkg::RES_W'(MAX_RESOLUTION);
		end else begin
			res_eff = {1'b0, res_q};
		end
		fs_full = (FS_W'(1) << res_eff) - FS_W'(1);
		fs      = fs_full[MR-1:0];

		if (action_q == qxm_pkg::ACT_TEST) begin
			duty_new = prod[qxm_pkg::RECIP_SHIFT +: MR];
		end else begin
			duty_new = prod[FRAC_BITS +: MR];
		end

		more = (action_q == qxm_pkg::ACT_MIX || action_q == qxm_pkg::ACT_FOUR)
		       && motor_q != 2'd3;

		out_free   = !m_tvalid_q || m_tready;
		show_stats = (action_q == qxm_pkg::ACT_READ) && !status_q;
		out_word   = OUT_W'({
			show_stats ? st_samples : '0,
			show_stats ? st_total   : '0,
			show_stats ? st_max     : '0,
			show_stats ? st_min     : '0,
			armed_q, mask_q,
			duty_q[3], duty_q[2], duty_q[1], duty_q[0]
		});
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			qxm_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (ignore_in) begin
						state_nx = qxm_pkg::ST_DONE;
					end else begin
						case (act_in)
							qxm_pkg::ACT_MIX:                   state_nx = qxm_pkg::ST_GAIN;
							qxm_pkg::ACT_FOUR, qxm_pkg::ACT_ONE: state_nx = qxm_pkg::ST_CLAMP;
							qxm_pkg::ACT_TEST:                  state_nx = qxm_pkg::ST_TMUL;
							default:                            state_nx = qxm_pkg::ST_DONE;
						endcase
					end
				end
			end
			qxm_pkg::ST_GAIN:  state_nx = qxm_pkg::ST_CLAMP;
			qxm_pkg::ST_CLAMP: state_nx = qxm_pkg::ST_DUTY;
			qxm_pkg::ST_DUTY:  state_nx = qxm_pkg::ST_WRITE;
			qxm_pkg::ST_TMUL:  state_nx = qxm_pkg::ST_TDIV;
			qxm_pkg::ST_TDIV:  state_nx = qxm_pkg::ST_WRITE;
			qxm_pkg::ST_WRITE: begin
				if (!more) begin
					state_nx = qxm_pkg::ST_DONE;
				end else if (action_q == qxm_pkg::ACT_MIX) begin
					state_nx = qxm_pkg::ST_GAIN;
				end else begin
					state_nx = qxm_pkg::ST_CLAMP;
				end
			end
			qxm_pkg::ST_DONE: begin
				if (out_free) begin
					state_nx = qxm_pkg::ST_IDLE;
				end
			end
			default: state_nx = qxm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, statistics update
	always_comb begin
		s_tready       = (state_q == qxm_pkg::ST_IDLE);
		accept         = s_tready && s_tvalid;
		mul_req        = '0;
		stat_req       = '0;
		stat_req.motor = motor_q;
		stat_req.value = qxm_pkg::VAL_MAX_W'(v_q);
		stat_req.clr   = accept && act_in == qxm_pkg::ACT_CLEAR;
		case (state_q)
			qxm_pkg::ST_GAIN: begin
				mul_req.en = 1'b1;
				mul_req.a  = qxm_pkg::MUL_W'(sum_sel);
				mul_req.b  = qxm_pkg::MUL_W'(gain_q);
			end
			qxm_pkg::ST_DUTY: begin
				mul_req.en  = 1'b1;
				mul_req.a   = qxm_pkg::MUL_W'(v_q);
				mul_req.b   = qxm_pkg::MUL_W'(fs);
				stat_req.wr = 1'b1;
			end
			qxm_pkg::ST_TMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = qxm_pkg::MUL_W'(pct_c);
				mul_req.b  = qxm_pkg::MUL_W'(fs);
			end
			qxm_pkg::ST_TDIV: begin
				// divide by 100 as a product with the scaled reciprocal
				mul_req.en = 1'b1;
				mul_req.a  = qxm_pkg::MUL_W'(prod[qxm_pkg::PROD_IN_W-1:0]);
				mul_req.b  = qxm_pkg::MUL_W'(qxm_pkg::RECIP);
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= qxm_pkg::ST_IDLE;
			action_q   <= qxm_pkg::ACT_MIX;
			res_q      <= qxm_pkg::RES_RESET;
			gain_q     <= qxm_pkg::GAIN_RESET;
			armed_q    <= 1'b0;
			motor_q    <= '0;
			status_q   <= 1'b0;
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				duty_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;

			if (cfg_wen) begin
				case (cfg_index)
					qxm_pkg::REG_RESOLUTION: res_q  <= cfg_wdata[qxm_pkg::RES_REG_W-1:0];
					qxm_pkg::REG_GAIN:       gain_q <= cfg_wdata;
					default:                 gain_q <= gain_q;
				endcase
			end

			if (accept) begin
				action_q <= act_in;
				status_q <= ignore_in;
				// disarm marks every motor, all else starts with an empty mask
				mask_q   <= (act_in == qxm_pkg::ACT_DISARM) ? 4'hF : 4'h0;
				if (act_in == qxm_pkg::ACT_ONE || act_in == qxm_pkg::ACT_TEST
				    || act_in == qxm_pkg::ACT_READ) begin
					motor_q <= idx_in[1:0];
				end else begin
					motor_q <= '0;
				end
				if (act_in == qxm_pkg::ACT_ARM) begin
					armed_q <= 1'b1;
				end
				if (act_in == qxm_pkg::ACT_DISARM) begin
					armed_q <= 1'b0;
					for (int i = 0; i < 4; i++) begin
						duty_q[i] <= '0;
					end
				end
			end

			if (state_q == qxm_pkg::ST_WRITE) begin
				duty_q[motor_q] <= duty_new;
				mask_q[motor_q] <= 1'b1;
				if (more) begin
					motor_q <= motor_q + 2'd1;
				end
			end

			// hold the result until the output register frees
			if (state_q == qxm_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= s_tdata[qxm_pkg::IN_USED_W-1:0];
		end
		if (state_q == qxm_pkg::ST_CLAMP) begin
			v_q <= v_clamp;
		end
		if (state_q == qxm_pkg::ST_DONE && out_free) begin
			m_tdata_q <= out_word;
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
